// ===== rtl/core/lrps_pkg.sv =====
// Shared types, constants and helper functions of the LBA range page splitter.
package lrps_pkg;

   localparam int SECTOR_SIZE_SHIFT   = 9;
   localparam int MAX_REQUEST_SECTORS = 64;

   localparam int LBA_W    = 48;
   localparam int COUNT_W  = 7;
   localparam int NS_W     = 32;
   localparam int WK_W     = 8;
   localparam int MASK_W   = 64;
   localparam int BYTES_W  = 16;
   localparam int SPP_W    = 7;
   localparam int OFF_W    = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_SPP = 1'b0;
   localparam logic [SPP_W-1:0] SPP_RESET = 7'd8;

   // Quotient bits resolved per divider cycle.
   localparam int DIV_STEP_BITS = 8;
   localparam int DIV_CYCLES    = LBA_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam int BYTES_WIDE_W = COUNT_W + SECTOR_SIZE_SHIFT;

   typedef struct packed {
      logic [LBA_W-1:0]   first_lba;
      logic [COUNT_W-1:0] num_sectors;
      logic               is_write;
      logic [NS_W-1:0]    namespace_id;
      logic [WK_W-1:0]    worker_id;
   } req_type;

   typedef struct packed {
      logic [LBA_W-1:0]   page_address;
      logic [MASK_W-1:0]  sector_mask;
      logic [BYTES_W-1:0] byte_length;
      logic               write_flag;
      logic [NS_W-1:0]    namespace_out;
      logic [WK_W-1:0]    worker_out;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_empty;
      logic last_now;
   } dp_status_type;

   // Zero acts as one sector per page, anything above the mask width as a full mask.
   function automatic logic [SPP_W-1:0] eff_spp(input logic [SPP_W-1:0] v);
      logic [SPP_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SPP_W'(1);
      end else if (v > SPP_W'(MASK_W)) begin
         r = SPP_W'(MASK_W);
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = v;
      if (v > COUNT_W'(MAX_REQUEST_SECTORS)) begin
         r = COUNT_W'(MAX_REQUEST_SECTORS);
      end
      return r;
   endfunction

   function automatic logic [MASK_W-1:0] run_mask(input logic [COUNT_W-1:0] len,
                                                  input logic [OFF_W-1:0]   off);
      logic [MASK_W-1:0] base;
      if (len >= COUNT_W'(MASK_W)) begin
         base = '1;
      end else begin
         base = (MASK_W'(1) << len) - MASK_W'(1);
      end
      return base << off;
   endfunction

endpackage

// ===== rtl/core/lrps_csr.sv =====
// Configuration register file holding the sectors-per-page setting.
module lrps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lrps_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lrps_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lrps_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [lrps_pkg::SPP_W-1:0]        spp
);
   import lrps_pkg::*;

   logic [SPP_W-1:0] spp_ff;
   logic [SPP_W-1:0] spp_in;
   logic             hit_spp;

   // Registers sit on 4-byte boundaries, so bit 2 selects the register.
   assign hit_spp = (paddr[2:2] == CSR_IDX_SPP);
   assign pready  = 1'b1;
   assign spp     = spp_ff;

   always_comb begin
      spp_in = spp_ff;
      if (psel && penable && pwrite && hit_spp) begin
         spp_in = pwdata[SPP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (hit_spp) begin
         prdata = CSR_DATA_W'(spp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff <= SPP_RESET;
      end else begin
         spp_ff <= spp_in;
      end
   end

endmodule

// ===== rtl/core/lrps_datapath.sv =====
// Datapath: page divider, segment length logic and the result register.
module lrps_datapath (
   input  logic                        clock,
   input  lrps_pkg::req_type           req_data,
   input  logic [lrps_pkg::SPP_W-1:0]  spp,
   input  lrps_pkg::ctrl_cmd_type      cmd,
   output lrps_pkg::dp_status_type     status,
   output lrps_pkg::rsp_type           rsp_data
);
   import lrps_pkg::*;

   localparam logic [BYTES_WIDE_W-1:0] BytesMax = BYTES_WIDE_W'(2**BYTES_W - 1);

   // The dividend register turns into the quotient, which is then the page address.
   logic [LBA_W-1:0]   quot_ff,    quot_in;
   logic [OFF_W-1:0]   rem_ff,     rem_in;
   logic [SPP_W-1:0]   divisor_ff, divisor_in;
   logic [COUNT_W-1:0] remain_ff,  remain_in;
   logic               wr_ff,      wr_in;
   logic [NS_W-1:0]    ns_ff,      ns_in;
   logic [WK_W-1:0]    wk_ff,      wk_in;
   rsp_type            rsp_ff,     rsp_in;

   logic [LBA_W-1:0]        div_quot;
   logic [OFF_W-1:0]        div_rem;
   logic [SPP_W-1:0]        div_trial;
   logic [SPP_W-1:0]        seg_avail;
   logic [COUNT_W-1:0]      seg_len;
   logic [BYTES_WIDE_W-1:0] bytes_wide;
   logic [BYTES_W-1:0]      bytes_sat;

   // Restoring division, several quotient bits per cycle.
   always_comb begin
      div_quot  = quot_ff;
      div_rem   = rem_ff;
      div_trial = '0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         div_trial = {div_rem, div_quot[LBA_W-1]};
         div_quot  = {div_quot[LBA_W-2:0], 1'b0};
         if (div_trial >= divisor_ff) begin
            div_trial   = div_trial - divisor_ff;
            div_quot[0] = 1'b1;
         end
         div_rem = div_trial[OFF_W-1:0];
      end
   end

   // The first segment starts at the remainder offset, later ones at zero.
   assign seg_avail  = divisor_ff - SPP_W'(rem_ff);
   assign seg_len    = (seg_avail < remain_ff) ? COUNT_W'(seg_avail) : remain_ff;
   assign bytes_wide = BYTES_WIDE_W'(seg_len) << SECTOR_SIZE_SHIFT;
   assign bytes_sat  = (bytes_wide > BytesMax) ? BYTES_W'(BytesMax)
                                               : bytes_wide[BYTES_W-1:0];

   assign status.req_empty = (req_data.num_sectors == '0);
   assign status.last_now  = (seg_len == remain_ff);
   assign rsp_data         = rsp_ff;

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      remain_in  = remain_ff;
      wr_in      = wr_ff;
      ns_in      = ns_ff;
      wk_in      = wk_ff;
      rsp_in     = rsp_ff;
      if (cmd.load) begin
         quot_in    = req_data.first_lba;
         rem_in     = '0;
         divisor_in = eff_spp(spp);
         remain_in  = sat_count(req_data.num_sectors);
         wr_in      = req_data.is_write;
         ns_in      = req_data.namespace_id;
         wk_in      = req_data.worker_id;
      end else if (cmd.div_step) begin
         quot_in = div_quot;
         rem_in  = div_rem;
      end else if (cmd.emit) begin
         rsp_in.page_address  = quot_ff;
         rsp_in.sector_mask   = run_mask(seg_len, rem_ff);
         rsp_in.byte_length   = bytes_sat;
         rsp_in.write_flag    = wr_ff;
         rsp_in.namespace_out = ns_ff;
         rsp_in.worker_out    = wk_ff;
         rsp_in.last          = status.last_now;
         quot_in              = quot_ff + LBA_W'(1);
         rem_in               = '0;
         remain_in            = remain_ff - seg_len;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      remain_ff  <= remain_in;
      wr_ff      <= wr_in;
      ns_ff      <= ns_in;
      wk_ff      <= wk_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ===== rtl/core/lrps_ctrl.sv =====
// Controller: request intake, divider sequencing and result handshake.
module lrps_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  lrps_pkg::dp_status_type     status,
   output lrps_pkg::ctrl_cmd_type      cmd
);
   import lrps_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DIV_CYCLES - 1);

   logic [1:0]           state_ff,     state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff,   div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.load     = req_valid && req_ready;
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.emit     = (state_ff == ST_EMIT) && slot_free;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            div_cnt_in = '0;
            // An empty request is taken and produces nothing.
            if (cmd.load && !status.req_empty) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DivLast) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit && status.last_now) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !status.req_empty) |=> (state_ff == ST_DIV) && (div_cnt_ff == '0))
      else $error("non-empty request did not start the divider");

   a_divide_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff == DivLast) |=> (state_ff == ST_EMIT))
      else $error("divider did not hand over to segment output");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last_now) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("final segment did not close the request");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.emit)
      else $error("result register overwritten while stalled");
`endif

endmodule

// ===== rtl/core/lba_range_page_splitter_top.sv =====
// Top level of the LBA range page splitter: config registers, controller and datapath.
//
// Each request (up to 64 sectors) is split into one result per flash page it touches,
// in ascending page order. After a request is taken, the page divider resolves
// eight quotient bits per cycle to get the first page address and the in-page
// offset; the segments then follow at one result per cycle while the result side
// keeps taking them. The block takes no new request until the last segment of the
// current one has been emitted, and a request with a zero sector count is taken and
// yields nothing. The final result of a request may still wait on rsp_ready while the
// next request is accepted. The page size register sits at byte address 0 of the
// register port; the user must write it only while no request is in flight, as the
// block itself does not enforce this.
module lba_range_page_splitter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lrps_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lrps_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lrps_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lrps_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lrps_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import lrps_pkg::*;

   logic [SPP_W-1:0] spp;
   ctrl_cmd_type     cmd;
   dp_status_type    status;

   lrps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .spp     (spp)
   );

   lrps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrps_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .spp      (spp),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the LBA range page splitter: random and edge requests.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrps_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam logic [CSR_ADDR_W-1:0] SPP_ADDR = CSR_ADDR_W'({CSR_IDX_SPP, 2'b00});

   // Keeps the page size in force and the page transactions still owed by the block.
   class page_txn_board;
      logic [SPP_W-1:0] page_size;
      rsp_type pending_pages[$];
      int unsigned mismatches;

      function new();
         page_size = SPP_RESET;
         mismatches = 0;
      endfunction

      function void note_request(req_type r);
         longint unsigned span;
         longint unsigned sec;
         longint unsigned remain;
         longint unsigned off;
         longint unsigned len;
         longint unsigned bytes;
         logic [63:0] run;
         rsp_type t;
         span = page_size;
         if (span == 0) begin
            span = 1;
         end else if (span > 64) begin
            span = 64;
         end
         sec = r.first_lba;
         remain = r.num_sectors;
         if (remain > MAX_REQUEST_SECTORS) begin
            remain = MAX_REQUEST_SECTORS;
         end
         // The address runs on in 64 bits; only the page number is cut to 48 bits.
         while (remain != 0) begin
            off = sec % span;
            len = span - off;
            if (len > remain) begin
               len = remain;
            end
            run = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
            bytes = len << SECTOR_SIZE_SHIFT;
            if (bytes > 16'hFFFF) begin
               bytes = 16'hFFFF;
            end
            remain -= len;
            t.page_address  = LBA_W'(sec / span);
            t.sector_mask   = run << off;
            t.byte_length   = BYTES_W'(bytes);
            t.write_flag    = r.is_write;
            t.namespace_out = r.namespace_id;
            t.worker_out    = r.worker_id;
            t.last          = (remain == 0);
            pending_pages.push_back(t);
            sec += len;
         end
      endfunction

      function int unsigned field_diff(string name, logic [63:0] want, logic [63:0] got);
         if (want === got) begin
            return 0;
         end
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         return 1;
      endfunction

      function void check_page(rsp_type got);
         rsp_type want;
         if (pending_pages.size() == 0) begin
            $display("%0t: page transaction with none expected: expected nothing, got %p",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_pages.pop_front();
         mismatches += field_diff("page_address", want.page_address, got.page_address);
         mismatches += field_diff("sector_mask", want.sector_mask, got.sector_mask);
         mismatches += field_diff("byte_length", want.byte_length, got.byte_length);
         mismatches += field_diff("write_flag", want.write_flag, got.write_flag);
         mismatches += field_diff("namespace_out", want.namespace_out, got.namespace_out);
         mismatches += field_diff("worker_out", want.worker_out, got.worker_out);
         mismatches += field_diff("last", want.last, got.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned rsp_hold_len = 0;
   page_txn_board board = new();

   lba_range_page_splitter_top u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic req_type make_request(logic [LBA_W-1:0] lba, logic [COUNT_W-1:0] count,
                                            logic wr, logic [NS_W-1:0] ns,
                                            logic [WK_W-1:0] wk);
      req_type r;
      r.first_lba = lba;
      r.num_sectors = count;
      r.is_write = wr;
      r.namespace_id = ns;
      r.worker_id = wk;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      logic [63:0] wide;
      int unsigned pick;
      wide = {$urandom, $urandom};
      r.first_lba = wide[LBA_W-1:0];
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.first_lba = '1 - LBA_W'($urandom_range(80));
      end else if (pick < 25) begin
         r.first_lba = LBA_W'($urandom_range(200));
      end
      // Mostly short requests, with empty and oversized ones mixed in.
      pick = $urandom_range(99);
      if (pick < 6) begin
         r.num_sectors = '0;
      end else if (pick < 12) begin
         r.num_sectors = COUNT_W'($urandom_range(127, 65));
      end else if (pick < 60) begin
         r.num_sectors = COUNT_W'($urandom_range(16, 1));
      end else begin
         r.num_sectors = COUNT_W'($urandom_range(64, 17));
      end
      r.is_write = 1'($urandom_range(1));
      r.namespace_id = $urandom;
      r.worker_id = WK_W'($urandom_range(255));
      return r;
   endfunction

   task automatic offer_request(input req_type r);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_pages.size() != 0) @(posedge clock);
      // An empty request may still be in the block after the last page has left.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_page_size(input logic [SPP_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SPP_ADDR;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      board.page_size = value;
   endtask

   // Result side: checks every accepted page transaction and stalls as the phase asks.
   initial begin : page_sink
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            board.check_page(rsp_data);
         end
         if (rsp_hold_len != 0) begin
            hold_left = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned spp_plan[8] = '{64, 1, 3, 0, 100, 16, 127, 8};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Edge requests at the reset page size of eight sectors.
      offer_request(make_request('0, 7'd1, 1'b0, '0, '0));
      offer_request(make_request('0, 7'd64, 1'b1, '1, '1));
      offer_request(make_request(48'd7, 7'd2, 1'b0, 32'h1234_5678, 8'd1));
      offer_request(make_request(48'd5, 7'd3, 1'b1, 32'h8765_4321, 8'd2));
      offer_request(make_request(48'hAAAA_AAAA_AAAA, 7'd0, 1'b1, 32'h0F0F_0F0F, 8'd3));
      offer_request(make_request(48'h5555_5555_5555, 7'd127, 1'b0, 32'hAAAA_AAAA, 8'h55));
      offer_request(make_request('1, 7'd64, 1'b1, 32'h5555_5555, 8'hAA));
      offer_request(make_request(48'hFFFF_FFFF_FFF8, 7'd65, 1'b0, 32'hF0F0_F0F0, 8'h0F));
      offer_request(make_request(48'd3, 7'd8, 1'b1, 32'h0000_FFFF, 8'hF0));
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_page_size(SPP_W'(spp_plan[p]));
         case (p % 4)
            0: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct = 61;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct = 0;
               rsp_stall_pct = 61;
            end
            default: begin
               req_idle_pct = 38;
               rsp_stall_pct = 38;
            end
         endcase
         // A long result stall while requests keep coming backs the block up to its input.
         if (p == 0) begin
            rsp_hold_len = 400;
         end
         offer_request(make_request('0, 7'd64, 1'($urandom_range(1)), $urandom, '1));
         offer_request(make_request('1, 7'd127, 1'($urandom_range(1)), $urandom, '0));
         for (int i = 0; i < 38; i++) begin
            if (p == 5 && i == 19) begin
               wait_drained();
            end
            offer_request(random_request());
         end
         wait_drained();
      end

      if (board.mismatches == 0 && board.pending_pages.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/lrps_pkg.sv
rtl/core/lrps_csr.sv
rtl/core/lrps_datapath.sv
rtl/core/lrps_ctrl.sv
rtl/core/lba_range_page_splitter_top.sv
tb/tb.sv
